@@ rtl/brws_pkg.sv @@
// Package for the byte ring buffer with spans.
// Holds the operation codes, the status struct and small arithmetic helpers.
// No dependencies.
package brws_pkg;

   localparam int CW          = 11;   // width of counts, capacity and positions
   localparam int POS_W       = 10;   // width of the reported positions
   localparam int OP_W        = 3;
   localparam int DATA_W      = 8;
   localparam int DEPTH_DEF   = 1024;
   localparam int CAP_DEFAULT = 1024;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 3'd0,
      OP_READ    = 3'd1,
      OP_COMMIT  = 3'd2,
      OP_DISCARD = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef struct packed {
      logic [CW-1:0]    readable;
      logic [CW-1:0]    writable;
      logic [CW-1:0]    read_span;
      logic [CW-1:0]    write_span;
      logic [POS_W-1:0] read_position;
      logic [POS_W-1:0] write_position;
   } status_type;

   // Adds two positions or counts and wraps once at the capacity.
   function automatic logic [CW-1:0] wrap_add(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b,
                                               input logic [CW-1:0] cap);
      logic [CW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, cap}) begin
         sum = sum - {1'b0, cap};
      end
      return sum[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] min_cw(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

@@ rtl/brws_mem.sv @@
// Byte store of the ring buffer: one write port and one registered read port.
// Depends on brws_pkg for the data width.
module brws_mem
   import brws_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // The read register only loads on a read, so it holds while a result stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/brws_ctrl.sv @@
// Control of the ring buffer: capacity, tail, head and fill registers,
// the per-item update, the result register and the status reported with it.
// Depends on brws_pkg.
module brws_ctrl
   import brws_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CW-1:0]       csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CW-1:0]       req_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                mem_wr_en,
   output logic                mem_rd_en,
   output logic [CW-1:0]       head_pos,
   output logic [CW-1:0]       tail_pos,
   output logic                rd_sel,
   output logic [CW-1:0]       done_res,
   output status_type          status
);

   localparam logic [CW-1:0] CAP_RESET =
      CW'((DEPTH < CAP_DEFAULT) ? DEPTH : CAP_DEFAULT);

   logic [CW-1:0] cap_ff, cap_in;
   logic [CW-1:0] tail_ff, tail_in;
   logic [CW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] done_ff, done_in;
   logic          rd_sel_ff, rd_sel_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          accept;
   logic [CW-1:0] room;
   logic [CW-1:0] amount;
   op_type        op;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_op);
   assign room      = cap_ff - fill_ff;

   // Saturates a written capacity into the range one to DEPTH.
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_in = CW'(1);
      end else if (32'(csr_wr_data) > DEPTH) begin
         cap_in = CW'(DEPTH);
      end else begin
         cap_in = csr_wr_data;
      end
   end

   always_comb begin
      tail_in   = tail_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      done_in   = '0;
      rd_sel_in = 1'b0;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      amount    = '0;
      unique case (op)
         OP_WRITE: begin
            if (fill_ff != cap_ff) begin
               mem_wr_en = 1'b1;
               head_in   = wrap_add(head_ff, CW'(1), cap_ff);
               fill_in   = fill_ff + CW'(1);
               done_in   = CW'(1);
            end
         end
         OP_READ: begin
            if (fill_ff != '0) begin
               mem_rd_en = 1'b1;
               rd_sel_in = 1'b1;
               tail_in   = wrap_add(tail_ff, CW'(1), cap_ff);
               fill_in   = fill_ff - CW'(1);
               done_in   = CW'(1);
            end
         end
         OP_COMMIT: begin
            amount  = min_cw(req_count, room);
            head_in = wrap_add(head_ff, amount, cap_ff);
            fill_in = fill_ff + amount;
            done_in = amount;
         end
         OP_DISCARD: begin
            amount  = min_cw(req_count, fill_ff);
            tail_in = wrap_add(tail_ff, amount, cap_ff);
            fill_in = fill_ff - amount;
            done_in = amount;
         end
         OP_CLEAR: begin
            tail_in = '0;
            head_in = '0;
            fill_in = '0;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         mem_wr_en = 1'b0;
         mem_rd_en = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         tail_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff  <= cap_in;
            tail_ff <= '0;
            head_ff <= '0;
            fill_ff <= '0;
         end else if (accept) begin
            tail_ff <= tail_in;
            head_ff <= head_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff   <= done_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // The state registers hold the state after the item in the result register
   // unless the capacity is written meanwhile, so the status is derived from them.
   assign status.readable       = fill_ff;
   assign status.writable       = room;
   assign status.read_span      = min_cw(fill_ff, cap_ff - tail_ff);
   assign status.write_span     = min_cw(room, cap_ff - head_ff);
   assign status.read_position  = tail_ff[POS_W-1:0];
   assign status.write_position = head_ff[POS_W-1:0];

   assign rsp_valid = rsp_valid_ff;
   assign head_pos  = head_ff;
   assign tail_pos  = tail_ff;
   assign rd_sel    = rd_sel_ff;
   assign done_res  = done_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill exceeds capacity");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff < cap_ff)
      else $error("tail beyond capacity");

   a_head_track: assert property (@(posedge clock) disable iff (reset)
      head_ff == wrap_add(tail_ff, fill_ff, cap_ff))
      else $error("head out of step with tail and fill");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (fill_ff != cap_ff) && accept)
      else $error("store written while full");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |=> rsp_valid_ff && rd_sel_ff)
      else $error("store read without a read result");

endmodule

@@ rtl/byte_ring_buffer_with_spans.sv @@
// Top level of the byte ring buffer with spans.
// Instantiates brws_ctrl and brws_mem; depends on brws_pkg.
//
// A byte FIFO over the first capacity entries of a DEPTH-byte store. It accepts
// one item (write, read, commit, discard or clear) every clock cycle while no
// result is stalled, and returns exactly one result per item, in the cycle after
// acceptance: the tail, head and fill registers update on acceptance, and the
// read port of the store is registered. A result that is stalled
// holds the input side for as long as it waits. Writing the capacity (saturated
// to one through DEPTH) also empties the FIFO but keeps the stored bytes; write
// it only while no item is in flight, and follow it with a clear if desired.
// Reading a byte that was only committed and never written returns undefined
// data. There is no clearing pass after reset.
module byte_ring_buffer_with_spans
   import brws_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CW-1:0]     csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_op,
   input  logic [DATA_W-1:0] req_data_in,
   input  logic [CW-1:0]     req_count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic [CW-1:0]     rsp_done_res,
   output logic [CW-1:0]     rsp_readable,
   output logic [CW-1:0]     rsp_writable,
   output logic [CW-1:0]     rsp_read_span,
   output logic [CW-1:0]     rsp_write_span,
   output logic [POS_W-1:0]  rsp_read_position,
   output logic [POS_W-1:0]  rsp_write_position
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = (AW > CW) ? AW : CW;

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [CW-1:0]     head_pos;
   logic [CW-1:0]     tail_pos;
   logic [PW-1:0]     head_ext;
   logic [PW-1:0]     tail_ext;
   logic              rd_sel;
   logic [DATA_W-1:0] mem_rd_data;
   status_type        status;

   brws_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_count  (req_count),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .mem_wr_en  (mem_wr_en),
      .mem_rd_en  (mem_rd_en),
      .head_pos   (head_pos),
      .tail_pos   (tail_pos),
      .rd_sel     (rd_sel),
      .done_res   (rsp_done_res),
      .status     (status)
   );

   // Positions stay below the capacity, so they always fit the store address.
   assign head_ext = PW'(head_pos);
   assign tail_ext = PW'(tail_pos);

   brws_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(head_ext[AW-1:0]),
      .wr_data(req_data_in),
      .rd_en  (mem_rd_en),
      .rd_addr(tail_ext[AW-1:0]),
      .rd_data(mem_rd_data)
   );

   assign rsp_read_data      = rd_sel ? mem_rd_data : '0;
   assign rsp_readable       = status.readable;
   assign rsp_writable       = status.writable;
   assign rsp_read_span      = status.read_span;
   assign rsp_write_span     = status.write_span;
   assign rsp_read_position  = status.read_position;
   assign rsp_write_position = status.write_position;

endmodule
